/* hw/rtl/rgbhsv_pkg.sv */
package rgbhsv_pkg;

  // channel and result widths
  localparam int CH_W   = 8;
  localparam int HUE_W  = 9;
  localparam int NUM_W  = 2 * CH_W;

  // quotient bits of both divisions, and the default bits resolved per stage
  localparam int DIV_BITS      = CH_W;
  localparam int DIV_STEPS_DEF = 2;

  // hue constants in degrees
  localparam logic [HUE_W-1:0] HUE_GREEN_BASE = 9'd120;
  localparam logic [HUE_W-1:0] HUE_BLUE_BASE  = 9'd240;
  localparam logic [HUE_W-1:0] HUE_FULL       = 9'd360;

  // channel holding the maximum, red checked first
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // per-pixel data that rides alongside the dividers
  typedef struct packed {
    sector_t          sector;
    logic             neg;
    logic             grey;
    logic [CH_W-1:0]  mx;
  } side_t;

  // front end word handed to the dividers
  typedef struct packed {
    logic             valid;
    logic [NUM_W-1:0] sat_num;
    logic [NUM_W-1:0] hue_num;
    logic [CH_W-1:0]  delta;
    side_t            side;
  } front_t;

endpackage

/* hw/rtl/rgbhsv_front.sv */
module rgbhsv_front
  import rgbhsv_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [CH_W-1:0]  red,
  input  logic [CH_W-1:0]  green,
  input  logic [CH_W-1:0]  blue,
  output front_t           front
);

  logic [CH_W-1:0] mx_c, mn_c, rg_max, rg_min, opa_c, opb_c;
  sector_t         sector_c;

  // stage a registers
  logic            a_valid;
  logic [CH_W-1:0] a_mx;
  logic [CH_W-1:0] a_delta;
  logic [CH_W-1:0] a_mag;
  logic            a_neg;
  sector_t         a_sector;

  logic [NUM_W-1:0] sat_num_c, hue_num_c;

  // max, min and hue sector
  always_comb begin
    rg_max = (red > green) ? red : green;
    rg_min = (red < green) ? red : green;
    mx_c   = (blue > rg_max) ? blue : rg_max;
    mn_c   = (blue < rg_min) ? blue : rg_min;
    if (red == mx_c) begin
      sector_c = SEC_RED;
    end else if (green == mx_c) begin
      sector_c = SEC_GREEN;
    end else begin
      sector_c = SEC_BLUE;
    end
  end

  // operands of the signed hue difference
  always_comb begin
    case (sector_c)
      SEC_RED: begin
        opa_c = green;
        opb_c = blue;
      end
      SEC_GREEN: begin
        opa_c = blue;
        opb_c = red;
      end
      default: begin
        opa_c = red;
        opb_c = green;
      end
    endcase
  end

  // stage a: extremes, delta, difference as sign and magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    a_mx     <= mx_c;
    a_delta  <= mx_c - mn_c;
    a_sector <= sector_c;
    a_neg    <= opa_c < opb_c;
    a_mag    <= (opa_c < opb_c) ? (opb_c - opa_c) : (opa_c - opb_c);
  end

  // numerators: delta*255 and |diff|*60 by shift and subtract
  assign sat_num_c = {a_delta, {CH_W{1'b0}}} - {{CH_W{1'b0}}, a_delta};
  assign hue_num_c = {2'b00, a_mag, 6'b000000} - {6'b000000, a_mag, 2'b00};

  // stage b
  always_ff @(posedge clk) begin
    if (rst) begin
      front.valid <= 1'b0;
    end else begin
      front.valid <= a_valid;
    end
    front.sat_num     <= sat_num_c;
    front.hue_num     <= hue_num_c;
    front.delta       <= a_delta;
    front.side.sector <= a_sector;
    front.side.neg    <= a_neg;
    front.side.grey   <= a_delta == '0;
    front.side.mx     <= a_mx;
  end

endmodule

/* hw/rtl/rgbhsv_div.sv */
module rgbhsv_div
  import rgbhsv_pkg::*;
#(
  parameter int STEPS = DIV_STEPS_DEF
)
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [CH_W-1:0]  den,
  output logic             out_valid,
  output logic [CH_W-1:0]  quo
);

  // restoring division, STEPS quotient bits per stage; the caller
  // guarantees num[15:8] < den so the quotient fits in 8 bits
  localparam int NST = DIV_BITS / STEPS;

  logic [CH_W-1:0] rem_s [NST+1];
  logic [CH_W-1:0] low_s [NST+1];
  logic [CH_W-1:0] den_s [NST+1];
  logic            vld_s [NST+1];

  assign rem_s[0] = num[NUM_W-1:CH_W];
  assign low_s[0] = num[CH_W-1:0];
  assign den_s[0] = den;
  assign vld_s[0] = in_valid;

  for (genvar g = 0; g < NST; g++) begin : g_stage
    logic [CH_W-1:0] rem_next;
    logic [CH_W-1:0] low_next;
    logic [CH_W-1:0] stage_rem;
    logic [CH_W-1:0] stage_low;
    logic [CH_W-1:0] stage_den;
    logic            stage_vld;

    // shift in one numerator bit, subtract when it fits
    always_comb begin
      logic [CH_W:0]   trial;
      logic [CH_W-1:0] r;
      logic [CH_W-1:0] l;
      r = rem_s[g];
      l = low_s[g];
      for (int k = 0; k < STEPS; k++) begin
        trial = {r, l[CH_W-1]};
        if (trial >= {1'b0, den_s[g]}) begin
          r = CH_W'(trial - {1'b0, den_s[g]});
          l = {l[CH_W-2:0], 1'b1};
        end else begin
          r = trial[CH_W-1:0];
          l = {l[CH_W-2:0], 1'b0};
        end
      end
      rem_next = r;
      low_next = l;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_vld <= 1'b0;
      end else begin
        stage_vld <= vld_s[g];
      end
      stage_rem <= rem_next;
      stage_low <= low_next;
      stage_den <= den_s[g];
    end

    assign vld_s[g+1] = stage_vld;
    assign rem_s[g+1] = stage_rem;
    assign low_s[g+1] = stage_low;
    assign den_s[g+1] = stage_den;
  end

  assign out_valid = vld_s[NST];
  assign quo       = low_s[NST];

endmodule

/* hw/rtl/rgb_to_hsv_converter_unit.sv */
// rgb to hsv converter, one 8-bit rgb pixel in, one hue/saturation/value word out
// path: front-end stage a, front-end stage b, the divider stages, then the output register;
// done is high while the word is on the outputs, and the word is taken at the edge that ends it
// throughput: one pixel per clock; busy is high only while rst is high
// the depth is set by the two restoring dividers, DIV_STEPS quotient bits per stage
// rst (synchronous) empties the pipeline; the receiver cannot stall, done is a strobe
module rgb_to_hsv_converter_unit
  import rgbhsv_pkg::*;
#(
  parameter int DIV_STEPS = DIV_STEPS_DEF
)
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [CH_W-1:0]   red,
  input  logic [CH_W-1:0]   green,
  input  logic [CH_W-1:0]   blue,
  output logic              done,
  output logic [HUE_W-1:0]  hue,
  output logic [CH_W-1:0]   saturation,
  output logic [CH_W-1:0]   brightness
);

  localparam int NST = DIV_BITS / DIV_STEPS;
  localparam int LAT = NST + 3;

  front_t          front;
  logic            sat_valid, hue_valid;
  logic [CH_W-1:0] sat_q, hue_q;
  side_t           side_s [NST];
  side_t           side_o;
  logic [HUE_W-1:0] hue_c;
  logic [HUE_W-1:0] q9;

  assign busy = rst;

  rgbhsv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .front    (front)
  );

  // saturation divider: delta*255 / max
  rgbhsv_div #(.STEPS(DIV_STEPS)) u_div_sat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front.valid),
    .num       (front.sat_num),
    .den       (front.side.mx),
    .out_valid (sat_valid),
    .quo       (sat_q)
  );

  // hue divider: |diff|*60 / delta
  rgbhsv_div #(.STEPS(DIV_STEPS)) u_div_hue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front.valid),
    .num       (front.hue_num),
    .den       (front.delta),
    .out_valid (hue_valid),
    .quo       (hue_q)
  );

  // sideband delay matching the dividers
  always_ff @(posedge clk) begin
    side_s[0] <= front.side;
    for (int i = 1; i < NST; i++) begin
      side_s[i] <= side_s[i-1];
    end
  end

  assign side_o = side_s[NST-1];
  assign q9     = {1'b0, hue_q};

  // hue from sector base and truncated quotient, wrapped into 0..359
  always_comb begin
    case (side_o.sector)
      SEC_RED: begin
        if (side_o.neg && hue_q != '0) begin
          hue_c = HUE_FULL - q9;
        end else begin
          hue_c = q9;
        end
      end
      SEC_GREEN: hue_c = side_o.neg ? (HUE_GREEN_BASE - q9) : (HUE_GREEN_BASE + q9);
      default:   hue_c = side_o.neg ? (HUE_BLUE_BASE - q9) : (HUE_BLUE_BASE + q9);
    endcase
  end

  // output word, grey and black forced to zero hue and saturation
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sat_valid;
    end
    hue        <= side_o.grey ? '0 : hue_c;
    saturation <= side_o.grey ? '0 : sat_q;
    brightness <= side_o.mx;
  end

  // both dividers move in lockstep
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    sat_valid == hue_valid)
    else $error("divider valids out of step");

  // every accepted word comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("accepted word not delivered on time");

  // no word appears without an accept
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result word without an accepted input");

  // hue stays within one turn
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    done |-> hue < HUE_FULL)
    else $error("hue out of range");

  // zero saturation only for grey or black, which has zero hue
  a_grey_hue: assert property (@(posedge clk) disable iff (rst)
    (done && saturation == '0) |-> hue == '0)
    else $error("grey pixel with nonzero hue");

endmodule

/* verif/tb_top.sv */
module tb_top;
  import rgbhsv_pkg::*;

  localparam int HUE_STEP  = 60;
  localparam int SAT_SCALE = 255;
  // margin after the drain, beyond the deepest pipeline, which has one quotient bit per stage
  localparam int SETTLE_CYCLES = 20;

  // one converted pixel, with the rgb word it came from for reporting
  typedef struct {
    logic [CH_W-1:0]  r;
    logic [CH_W-1:0]  g;
    logic [CH_W-1:0]  b;
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  sat;
    logic [CH_W-1:0]  val;
  } hsv_word_t;

  // shapes of random pixels
  typedef enum int {
    PIX_ANY,
    PIX_GREY,
    PIX_TIE_MAX,
    PIX_TIE_MIN,
    PIX_DIM
  } pix_kind_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [CH_W-1:0]   red;
  logic [CH_W-1:0]   green;
  logic [CH_W-1:0]   blue;
  logic              done;
  logic [HUE_W-1:0]  hue;
  logic [CH_W-1:0]   saturation;
  logic [CH_W-1:0]   brightness;

  hsv_word_t expected_hsv[$];
  hsv_word_t oldest_hsv;
  int        mismatch_count;

  rgb_to_hsv_converter_unit dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .done       (done),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hsv of one pixel, sector picked red first, then green, then blue
  function automatic hsv_word_t predict_hsv(input logic [CH_W-1:0] r,
                                            input logic [CH_W-1:0] g,
                                            input logic [CH_W-1:0] b);
    int        ri;
    int        gi;
    int        bi;
    int        mx;
    int        mn;
    int        delta;
    int        h;
    sector_t   sec;
    hsv_word_t w;
    ri = r;
    gi = g;
    bi = b;
    mx = (ri > gi) ? ri : gi;
    if (bi > mx) mx = bi;
    mn = (ri < gi) ? ri : gi;
    if (bi < mn) mn = bi;
    delta = mx - mn;
    w.r = r;
    w.g = g;
    w.b = b;
    w.hue = '0;
    w.sat = '0;
    w.val = mx[CH_W-1:0];
    h = 0;
    // black and grey leave hue and saturation at zero
    if (mx != 0 && delta != 0) begin
      w.sat = CH_W'((delta * SAT_SCALE) / mx);
      if (ri == mx) sec = SEC_RED;
      else if (gi == mx) sec = SEC_GREEN;
      else sec = SEC_BLUE;
      case (sec)
        SEC_RED: begin
          h = ((gi - bi) * HUE_STEP) / delta;
        end
        SEC_GREEN: begin
          h = int'(HUE_GREEN_BASE) + ((bi - ri) * HUE_STEP) / delta;
        end
        default: begin
          h = int'(HUE_BLUE_BASE) + ((ri - gi) * HUE_STEP) / delta;
        end
      endcase
      if (h < 0) h += int'(HUE_FULL);
      w.hue = h[HUE_W-1:0];
    end
    return w;
  endfunction

  // present one rgb word and hold it until the edge that takes it
  task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                            input logic [CH_W-1:0] b);
    bit taken;
    start <= 1'b1;
    red   <= r;
    green <= g;
    blue  <= b;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
    end
    expected_hsv.push_back(predict_hsv(r, g, b));
  endtask

  // drop start for a number of cycles, zero keeps the stream going
  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold off until every expected word has come back
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (expected_hsv.size() != 0) @(posedge clk);
  endtask

  // random pixel of a given shape
  task automatic send_random_pixel(input pix_kind_t kind);
    logic [CH_W-1:0] hi;
    logic [CH_W-1:0] lo;
    logic [CH_W-1:0] ch[3];
    int              pick;
    hi = CH_W'($urandom_range(0, 255));
    lo = CH_W'($urandom_range(0, hi));
    pick = $urandom_range(0, 2);
    ch[0] = CH_W'($urandom_range(0, 255));
    ch[1] = CH_W'($urandom_range(0, 255));
    ch[2] = CH_W'($urandom_range(0, 255));
    case (kind)
      PIX_GREY: begin
        ch[0] = hi;
        ch[1] = hi;
        ch[2] = hi;
      end
      PIX_TIE_MAX: begin
        // two channels share the maximum, the third is below
        ch[0] = hi;
        ch[1] = hi;
        ch[2] = hi;
        ch[pick] = lo;
      end
      PIX_TIE_MIN: begin
        ch[0] = lo;
        ch[1] = lo;
        ch[2] = lo;
        ch[pick] = hi;
      end
      PIX_DIM: begin
        ch[0] = CH_W'($urandom_range(0, 3));
        ch[1] = CH_W'($urandom_range(0, 3));
        ch[2] = CH_W'($urandom_range(0, 3));
      end
      default: begin
      end
    endcase
    send_pixel(ch[0], ch[1], ch[2]);
  endtask

  // black, white, greys, primaries, secondaries and wrap-around hues
  task automatic test_corner_pixels();
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd1,   8'd1,   8'd1);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    idle_cycles(2);
    // red sector with negative difference, truncated toward zero then wrapped
    send_pixel(8'd255, 8'd0,   8'd1);
    send_pixel(8'd255, 8'd0,   8'd10);
    send_pixel(8'd200, 8'd13,  8'd170);
    // smallest nonzero maximum in each sector
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd1,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd1,   8'd0,   8'd1);
    // smallest delta and a near-grey blue
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd254, 8'd254, 8'd255);
    send_pixel(8'd170, 8'd85,  8'd0);
    send_pixel(8'd10,  8'd200, 8'd255);
    idle_cycles(3);
  endtask

  // one word per clock with no gaps
  task automatic test_back_to_back();
    repeat (60) send_random_pixel(PIX_ANY);
    idle_cycles(1);
  endtask

  // a short burst, then a full drain before going on
  task automatic test_drain_pause();
    repeat (12) send_random_pixel(PIX_ANY);
    wait_drained();
    repeat (5) send_random_pixel(PIX_TIE_MAX);
    wait_drained();
  endtask

  // bursts of mixed pixel shapes with random gaps
  task automatic test_random_pixels(input int count);
    int        sent;
    int        burst;
    pix_kind_t kind;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        if ($urandom_range(0, 9) < 5) kind = PIX_ANY;
        else kind = pix_kind_t'($urandom_range(1, 4));
        send_random_pixel(kind);
        sent++;
      end
      if ($urandom_range(0, 7) == 0) idle_cycles(0);
      else idle_cycles($urandom_range(1, 8));
    end
    idle_cycles(1);
  endtask

  // compare each strobed word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_hsv.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected word: hue=%0d sat=%0d val=%0d",
                   hue, saturation, brightness);
      end else begin
        oldest_hsv = expected_hsv.pop_front();
        if (hue !== oldest_hsv.hue || saturation !== oldest_hsv.sat ||
            brightness !== oldest_hsv.val) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("rgb=(%0d,%0d,%0d) expected hsv=(%0d,%0d,%0d) got (%0d,%0d,%0d)",
                     oldest_hsv.r, oldest_hsv.g, oldest_hsv.b,
                     oldest_hsv.hue, oldest_hsv.sat, oldest_hsv.val,
                     hue, saturation, brightness);
        end
      end
    end
  end

  // sequence of tests
  initial begin
    mismatch_count = 0;
    rst   <= 1'b1;
    start <= 1'b0;
    red   <= '0;
    green <= '0;
    blue  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_pixels();
    test_back_to_back();
    test_drain_pause();
    test_random_pixels(1350);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_hsv.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // overall time limit
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
